// ----- hdl/mhrr_pkg.sv -----
// ----------------------------------------------------------------------------
// mhrr_pkg
// Shared constants and codes for the multichannel history ring reader.
// ----------------------------------------------------------------------------
package mhrr_pkg;

  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned SAMPLE_BITS  = 24;
  localparam int unsigned MAX_READ     = 64;

  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned CHSEL_W  = 4;
  localparam int unsigned CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned VALUE_W  = 27;
  localparam int unsigned PAIR_W   = SAMPLE_BITS + 1;
  localparam int unsigned NPAIR    = (MAX_CHANNELS + 1) / 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(DEPTH);
  localparam logic [CHSEL_W-1:0] ACT_RESET = CHSEL_W'(2);

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HISTORY_LENGTH  = 2'd0,
    REG_ACTIVE_CHANNELS = 2'd1,
    REG_SPARE_2         = 2'd2,
    REG_SPARE_3         = 2'd3
  } reg_idx_e;

endpackage

// ----- hdl/mhrr_ram.sv -----
// ----------------------------------------------------------------------------
// mhrr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mhrr_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/multichannel_history_ring_reader.sv -----
// ----------------------------------------------------------------------------
// multichannel_history_ring_reader
// Ring history of multichannel frames, one RAM bank per channel; reads return
// one channel or the sum of all active channels.
// ----------------------------------------------------------------------------
// push and clear: busy stays low; a new item is taken every cycle in which busy is low
// read of n samples: setup state, then one RAM read per cycle; results one per cycle
//   via RAM, pair-sum and output registers; busy while reads are issued or in flight
// empty or absent-channel read: one result the cycle after start, busy stays low
// results are strobed for one cycle; the receiver cannot stall them
// reset: history empty, history_length 1024, active_channels 2, RAM not cleared
module multichannel_history_ring_reader (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_we_i,
  input  logic [mhrr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mhrr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [1:0]                          kind_i,
  input  logic signed [mhrr_pkg::SAMPLE_BITS-1:0] sample_0_i,
  input  logic signed [mhrr_pkg::SAMPLE_BITS-1:0] sample_1_i,
  input  logic signed [mhrr_pkg::SAMPLE_BITS-1:0] sample_2_i,
  input  logic signed [mhrr_pkg::SAMPLE_BITS-1:0] sample_3_i,
  input  logic signed [mhrr_pkg::SAMPLE_BITS-1:0] sample_4_i,
  input  logic signed [mhrr_pkg::SAMPLE_BITS-1:0] sample_5_i,
  input  logic signed [mhrr_pkg::SAMPLE_BITS-1:0] sample_6_i,
  input  logic signed [mhrr_pkg::SAMPLE_BITS-1:0] sample_7_i,
  input  logic [mhrr_pkg::CHSEL_W-1:0]        read_channel_i,
  input  logic [mhrr_pkg::LEN_W-1:0]          back_offset_i,
  input  logic [mhrr_pkg::CNT_W-1:0]          read_count_i,
  output logic                                result_valid_o,
  output logic signed [mhrr_pkg::VALUE_W-1:0] value_o,
  output logic [mhrr_pkg::POS_W-1:0]          position_o,
  output logic [mhrr_pkg::CNT_W-1:0]          returned_count_o,
  output logic                                last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ISSUE
  } state_e;

  localparam int unsigned AW = mhrr_pkg::ADDR_W;
  localparam int unsigned LW = mhrr_pkg::LEN_W;
  localparam int unsigned SW = mhrr_pkg::SAMPLE_BITS;
  localparam int unsigned CW = mhrr_pkg::CNT_W;
  localparam int unsigned PW = mhrr_pkg::POS_W;
  localparam int unsigned VW = mhrr_pkg::VALUE_W;
  localparam int unsigned QW = mhrr_pkg::PAIR_W;
  localparam int unsigned NC = mhrr_pkg::MAX_CHANNELS;
  localparam int unsigned NP = mhrr_pkg::NPAIR;

  // configuration and ring state
  logic [LW-1:0]                    len_q;
  logic [mhrr_pkg::CHSEL_W-1:0]     act_q;
  logic [AW-1:0]                    wp_q;
  logic [LW-1:0]                    filled_q;

  // read control
  state_e                           state_q;
  logic [mhrr_pkg::CHSEL_W-1:0]     sel_q;
  logic                             sum_q;
  logic [LW-1:0]                    back_q;
  logic [CW-1:0]                    n_q;
  logic [CW-1:0]                    k_q;
  logic [AW-1:0]                    raddr_q;

  // pipeline after the RAM
  logic                             s1_vld_q;
  logic [PW-1:0]                    s1_pos_q;
  logic                             s1_last_q;
  logic                             s2_vld_q;
  logic [PW-1:0]                    s2_pos_q;
  logic                             s2_last_q;
  logic signed [QW-1:0]             pair_q [NP];

  logic                             out_vld_q;
  logic signed [VW-1:0]             out_value_q;
  logic [PW-1:0]                    out_pos_q;
  logic [CW-1:0]                    out_cnt_q;
  logic                             out_last_q;

  logic                             accept;
  mhrr_pkg::kind_e                  kind;
  logic [SW-1:0]                    samples [NC];
  logic [SW-1:0]                    rdata [NC];
  logic [NC-1:0]                    ch_en;
  logic                             re;

  logic [CW-1:0]                    req_sat;
  logic [CW-1:0]                    n_d;
  logic                             sum_d;
  logic                             absent_d;

  logic [LW-1:0]                    back_c;
  logic [LW:0]                      start_tmp;
  logic [LW:0]                      start_d;

  logic signed [QW-1:0]             pair_d [NP];
  logic signed [VW-1:0]             total_d;
  logic [LW-1:0]                    len_cfg;
  logic [mhrr_pkg::CHSEL_W-1:0]     act_cfg;
  logic [AW-1:0]                    wp_inc;
  logic [CW-1:0]                    k_inc;
  logic                             issue_last;

  assign kind   = mhrr_pkg::kind_e'(kind_i);
  assign busy   = (state_q != ST_IDLE) || s1_vld_q || s2_vld_q;
  assign accept = start && !busy;

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;

  always_comb begin
    for (int ch = 0; ch < NC; ch++) begin
      ch_en[ch] = mhrr_pkg::CHSEL_W'(ch) < act_q;
    end
  end

  assign re = (state_q == ST_ISSUE);

  for (genvar g = 0; g < NC; g++) begin : g_bank
    mhrr_ram #(
      .Depth(mhrr_pkg::DEPTH),
      .Width(SW)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (accept && (kind == mhrr_pkg::KIND_PUSH) && ch_en[g]),
      .waddr_i(wp_q),
      .wdata_i(samples[g]),
      .re_i   (re),
      .raddr_i(raddr_q),
      .rdata_o(rdata[g])
    );
  end

  // register saturation
  always_comb begin
    len_cfg = cfg_wdata_i[LW-1:0];
    if (len_cfg == '0) begin
      len_cfg = LW'(1);
    end else if (len_cfg > LW'(mhrr_pkg::DEPTH)) begin
      len_cfg = LW'(mhrr_pkg::DEPTH);
    end
    act_cfg = cfg_wdata_i[mhrr_pkg::CHSEL_W-1:0];
    if (act_cfg == '0) begin
      act_cfg = mhrr_pkg::CHSEL_W'(1);
    end else if (act_cfg > mhrr_pkg::CHSEL_W'(NC)) begin
      act_cfg = mhrr_pkg::CHSEL_W'(NC);
    end
  end

  // read decode at accept
  always_comb begin
    req_sat  = (read_count_i > CW'(mhrr_pkg::MAX_READ)) ? CW'(mhrr_pkg::MAX_READ)
                                                         : read_count_i;
    n_d      = ({{(LW-CW){1'b0}}, req_sat} < filled_q) ? req_sat : filled_q[CW-1:0];
    sum_d    = (read_channel_i == mhrr_pkg::CHSEL_W'(NC));
    absent_d = (!sum_d && (read_channel_i >= act_q)) || (n_d == '0);
  end

  // window start: clamp the distance into [n, filled], then wrap once
  always_comb begin
    back_c = back_q;
    if (back_c < {{(LW-CW){1'b0}}, n_q}) begin
      back_c = {{(LW-CW){1'b0}}, n_q};
    end
    if (back_c > filled_q) begin
      back_c = filled_q;
    end
    start_tmp = {{(LW+1-AW){1'b0}}, wp_q} + {1'b0, len_q} - {1'b0, back_c};
    start_d   = (start_tmp >= {1'b0, len_q}) ? (start_tmp - {1'b0, len_q}) : start_tmp;
  end

  assign wp_inc     = ((LW'(wp_q) + LW'(1)) == len_q) ? '0 : (wp_q + AW'(1));
  assign k_inc      = k_q + CW'(1);
  assign issue_last = (k_inc == n_q);

  // pair sums of sign-extended bank outputs, or the selected bank alone in pair 0
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      pair_d[p] = '0;
    end
    if (sum_q) begin
      for (int ch = 0; ch < NC; ch++) begin
        if (ch_en[ch]) begin
          pair_d[ch/2] = pair_d[ch/2] + QW'($signed(rdata[ch]));
        end
      end
    end else begin
      pair_d[0] = QW'($signed(rdata[sel_q[mhrr_pkg::CH_IDX_W-1:0]]));
    end
  end

  always_comb begin
    total_d = '0;
    for (int p = 0; p < NP; p++) begin
      total_d = total_d + VW'(pair_q[p]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= mhrr_pkg::LEN_RESET;
      act_q      <= mhrr_pkg::ACT_RESET;
      wp_q       <= '0;
      filled_q   <= '0;
      state_q    <= ST_IDLE;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      k_q        <= '0;
    end else begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;

      if (cfg_we_i) begin
        unique case (mhrr_pkg::reg_idx_e'(cfg_index_i))
          mhrr_pkg::REG_HISTORY_LENGTH: begin
            len_q    <= len_cfg;
            wp_q     <= '0;
            filled_q <= '0;
          end
          mhrr_pkg::REG_ACTIVE_CHANNELS: begin
            act_q    <= act_cfg;
            wp_q     <= '0;
            filled_q <= '0;
          end
          default: begin
          end
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (kind)
              mhrr_pkg::KIND_PUSH: begin
                wp_q <= wp_inc;
                if (filled_q < len_q) begin
                  filled_q <= filled_q + LW'(1);
                end
              end
              mhrr_pkg::KIND_CLEAR: begin
                wp_q     <= '0;
                filled_q <= '0;
              end
              mhrr_pkg::KIND_READ: begin
                if (absent_d) begin
                  out_vld_q <= 1'b1;
                end else begin
                  state_q <= ST_SETUP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SETUP: begin
          k_q     <= '0;
          state_q <= ST_ISSUE;
        end
        ST_ISSUE: begin
          s1_vld_q <= 1'b1;
          k_q      <= k_inc;
          if (issue_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept && (kind == mhrr_pkg::KIND_READ)) begin
      sel_q  <= read_channel_i;
      sum_q  <= sum_d;
      back_q <= back_offset_i;
      n_q    <= n_d;
    end
    if (state_q == ST_SETUP) begin
      raddr_q <= start_d[AW-1:0];
    end else if (state_q == ST_ISSUE) begin
      raddr_q <= ((LW'(raddr_q) + LW'(1)) == len_q) ? '0 : (raddr_q + AW'(1));
    end
    if (state_q == ST_ISSUE) begin
      s1_pos_q  <= k_q[PW-1:0];
      s1_last_q <= issue_last;
    end
    s2_pos_q  <= s1_pos_q;
    s2_last_q <= s1_last_q;
    for (int p = 0; p < NP; p++) begin
      pair_q[p] <= pair_d[p];
    end
    // empty or absent read gives a single zero item
    if (accept && (kind == mhrr_pkg::KIND_READ) && absent_d) begin
      out_value_q <= '0;
      out_pos_q   <= '0;
      out_cnt_q   <= '0;
      out_last_q  <= 1'b1;
    end else begin
      out_value_q <= total_d;
      out_pos_q   <= s2_pos_q;
      out_cnt_q   <= n_q;
      out_last_q  <= s2_last_q;
    end
  end

  assign result_valid_o   = out_vld_q;
  assign value_o          = out_value_q;
  assign position_o       = out_pos_q;
  assign returned_count_o = out_cnt_q;
  assign last_o           = out_last_q;

endmodule
